FILE: sv/assert_macros.svh
// Assertion macros shared by the header rewrite RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define ASSERT_SYNC(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/ahrc_pkg.sv
// Shared types, constants and byte functions for the header rewriter.
`timescale 1ns / 1ps

package ahrc_pkg;

   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [CsrAddrWidth-1:0] CsrDhcpEnable = 3'd0;
   localparam logic [CsrAddrWidth-1:0] CsrIpAddress  = 3'd1;
   localparam logic [CsrAddrWidth-1:0] CsrNetMask    = 3'd2;
   localparam logic [CsrAddrWidth-1:0] CsrGateway    = 3'd3;
   localparam logic [CsrAddrWidth-1:0] CsrDns        = 3'd4;

   localparam logic [4:0]  PassLastPos = 5'd3;
   localparam logic [4:0]  FlagPos     = 5'd4;
   localparam logic [4:0]  AddrFirstPos = 5'd5;
   localparam logic [4:0]  DataLastPos = 5'd20;
   localparam logic [4:0]  CrcHighPos  = 5'd21;
   localparam logic [4:0]  LastPos     = 5'd22;
   localparam logic [15:0] CrcPoly     = 16'h1021;

   typedef struct packed {
      logic        dhcp_enable;
      logic [31:0] ip_address;
      logic [31:0] net_mask;
      logic [31:0] gateway_address;
      logic [31:0] dns_address;
   } cfg_type;

   // Bit reverse then invert; it is its own inverse.
   function automatic logic [7:0] flip_byte(input logic [7:0] b);
      logic [7:0] r;
      for (int k = 0; k < 8; k++) begin
         r[7-k] = b[k];
      end
      return ~r;
   endfunction

   // CRC-16/XMODEM update over one byte, MSB first.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

FILE: sv/auth_header_rewrite_crc16.sv
// Top level of the authentication header rewriter with CRC-16/XMODEM.
//
//  channel  dir  handshake          payload
//  req      in   tvalid / tready    tdata = in_byte, tuser = first
//  rsp      out  tvalid / tready    tdata = out_byte, tlast = last_byte
//  csr      in   we (no wait)       addr = register index, wdata = value
//
// One item per cycle while rsp is not stalled; each item passes from req to rsp through
// the input register, then the rewrite and CRC update into the result register.
// The CRC byte update is a fixed XOR network in that one stage.
// Reset is synchronous and clears position, CRC, configuration registers and both valid flags.
// A stalled rsp holds the result; req keeps taking items until the input register is full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module auth_header_rewrite_crc16 (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] in_byte
   input  logic                              req_tuser,   // [0] first
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [7:0] out_byte
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [ahrc_pkg::CsrAddrWidth-1:0] csr_addr,
   input  logic [ahrc_pkg::CsrDataWidth-1:0] csr_wdata
);

   ahrc_pkg::cfg_type cfg;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_first_ff, in_first_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;

   logic       advance;
   logic [7:0] core_byte;
   logic       core_last;

   ahrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ahrc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .fire      (advance),
      .in_byte   (in_byte_ff),
      .first     (in_first_ff),
      .out_byte  (core_byte),
      .last_byte (core_last)
   );

   always_comb begin
      advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
      req_tready = !in_valid_ff || advance;

      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_first_in = in_first_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_first_in = req_tuser;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in  = core_byte;
         out_last_in  = core_last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff  <= in_byte_in;
      in_first_ff <= in_first_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

   `ASSERT_SYNC(a_full_blocks, in_valid_ff && out_valid_ff && !rsp_tready |-> !req_tready,
                "item taken while pipeline is full")
   `ASSERT_SYNC(a_out_source, $rose(out_valid_ff) |-> $past(in_valid_ff),
                "result without a buffered item")
   `ASSERT_SYNC(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast),
                "stalled result changed")

endmodule

FILE: sv/ahrc_csr.sv
// Configuration registers for the header rewriter.
`timescale 1ns / 1ps

module ahrc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ahrc_pkg::CsrAddrWidth-1:0]   csr_addr,
   input  logic [ahrc_pkg::CsrDataWidth-1:0]   csr_wdata,
   output ahrc_pkg::cfg_type                   cfg
);

   ahrc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            ahrc_pkg::CsrDhcpEnable: cfg_in.dhcp_enable     = csr_wdata[0];
            ahrc_pkg::CsrIpAddress:  cfg_in.ip_address      = csr_wdata;
            ahrc_pkg::CsrNetMask:    cfg_in.net_mask        = csr_wdata;
            ahrc_pkg::CsrGateway:    cfg_in.gateway_address = csr_wdata;
            ahrc_pkg::CsrDns:        cfg_in.dns_address     = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/ahrc_core.sv
// Header position and CRC state, and the per-byte rewrite logic.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ahrc_core (
   input  logic              clock,
   input  logic              reset,
   input  ahrc_pkg::cfg_type cfg,
   input  logic              fire,
   input  logic [7:0]        in_byte,
   input  logic              first,
   output logic [7:0]        out_byte,
   output logic              last_byte
);

   logic [4:0]  position_ff, position_in;
   logic [15:0] crc_ff, crc_in;

   logic        restart;
   logic [4:0]  pos_cur;
   logic [15:0] crc_cur;
   logic [3:0]  addr_idx;
   logic [31:0] addr_word;
   logic [7:0]  addr_byte;
   logic [7:0]  plain;

   always_comb begin
      restart  = first || (position_ff > ahrc_pkg::LastPos);
      pos_cur  = restart ? 5'd0 : position_ff;
      crc_cur  = restart ? 16'd0 : crc_ff;
      addr_idx = 4'(pos_cur - ahrc_pkg::AddrFirstPos);

      case (addr_idx[3:2])
         2'd0:    addr_word = cfg.ip_address;
         2'd1:    addr_word = cfg.net_mask;
         2'd2:    addr_word = cfg.gateway_address;
         default: addr_word = cfg.dns_address;
      endcase
      // most significant byte goes first
      case (addr_idx[1:0])
         2'd0:    addr_byte = addr_word[31:24];
         2'd1:    addr_byte = addr_word[23:16];
         2'd2:    addr_byte = addr_word[15:8];
         default: addr_byte = addr_word[7:0];
      endcase

      if (pos_cur <= ahrc_pkg::PassLastPos) begin
         plain = ahrc_pkg::flip_byte(in_byte);
      end else if (pos_cur == ahrc_pkg::FlagPos) begin
         plain = {7'd0, cfg.dhcp_enable};
      end else if (pos_cur <= ahrc_pkg::DataLastPos) begin
         plain = addr_byte;
      end else if (pos_cur == ahrc_pkg::CrcHighPos) begin
         plain = crc_cur[15:8];
      end else begin
         plain = crc_cur[7:0];
      end

      out_byte  = ahrc_pkg::flip_byte(plain);
      last_byte = (pos_cur == ahrc_pkg::LastPos);

      position_in = position_ff;
      crc_in      = crc_ff;
      if (fire) begin
         position_in = last_byte ? 5'd0 : pos_cur + 5'd1;
         crc_in      = (pos_cur <= ahrc_pkg::DataLastPos) ?
                       ahrc_pkg::crc16_byte(crc_cur, plain) : crc_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         crc_ff      <= '0;
      end else begin
         position_ff <= position_in;
         crc_ff      <= crc_in;
      end
   end

   `ASSERT_SYNC(a_pos_range, position_ff <= ahrc_pkg::LastPos, "position out of range")
   `ASSERT_SYNC(a_wrap, fire && last_byte |=> position_ff == 5'd0, "no wrap after last byte")
   `ASSERT_SYNC(a_crc_hold, fire && (pos_cur > ahrc_pkg::DataLastPos) |=> $stable(crc_ff),
                "crc changed while sending crc bytes")

endmodule

FILE: sim/auth_header_rewrite_crc16_check.sv
// Checker for the header rewriter: predicts each rewritten byte and compares it.
`timescale 1ns / 1ps

module auth_header_rewrite_crc16_check (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] in_byte
   input  logic                              req_tuser,   // [0] first
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [7:0]                        rsp_tdata,   // [7:0] out_byte
   input  logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [ahrc_pkg::CsrAddrWidth-1:0] csr_addr,
   input  logic [ahrc_pkg::CsrDataWidth-1:0] csr_wdata,
   output int                                error_count,
   output int                                pending_count
);

   localparam logic [4:0]  LastPassByte = 5'd3;
   localparam logic [4:0]  FlagByte     = 5'd4;
   localparam logic [4:0]  FirstAddrByte = 5'd5;
   localparam logic [4:0]  LastDataByte = 5'd20;
   localparam logic [4:0]  CrcHighByte  = 5'd21;
   localparam logic [4:0]  LastByte     = 5'd22;
   localparam logic [15:0] XmodemPoly   = 16'h1021;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rewritten_byte_type;

   rewritten_byte_type expected_bytes[$];

   logic [4:0]  hdr_pos;
   logic [15:0] running_crc;
   logic        flag_on;
   logic [31:0] ip_word;
   logic [31:0] mask_word;
   logic [31:0] gw_word;
   logic [31:0] dns_word;

   // reverse the bit order and invert; applying it twice gives the byte back
   function automatic logic [7:0] unscramble(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = ~b[7-i];
      end
      return r;
   endfunction

   // bit-serial form of the XMODEM update, data MSB first
   function automatic logic [15:0] xmodem_step(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ d[i];
         c = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ XmodemPoly;
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] address_byte(input logic [4:0] p);
      logic [4:0]  k;
      logic [31:0] w;
      k = p - FirstAddrByte;
      case (k[3:2])
         2'd0: w = ip_word;
         2'd1: w = mask_word;
         2'd2: w = gw_word;
         default: w = dns_word;
      endcase
      case (k[1:0])
         2'd0: return w[31:24];
         2'd1: return w[23:16];
         2'd2: return w[15:8];
         default: return w[7:0];
      endcase
   endfunction

   task automatic rewrite_byte(input logic [7:0] in_byte, input logic first);
      logic [4:0]         p;
      logic [15:0]        c;
      logic [7:0]         plain;
      rewritten_byte_type e;
      p = hdr_pos;
      c = running_crc;
      if (first || p > LastByte) begin
         p = '0;
         c = '0;
      end
      if (p <= LastPassByte) begin
         plain = unscramble(in_byte);
      end else if (p == FlagByte) begin
         plain = {7'b0, flag_on};
      end else if (p <= LastDataByte) begin
         plain = address_byte(p);
      end else if (p == CrcHighByte) begin
         plain = c[15:8];
      end else begin
         plain = c[7:0];
      end
      // CRC holds still across its own two bytes
      if (p <= LastDataByte) begin
         c = xmodem_step(c, plain);
      end
      e.out_byte = unscramble(plain);
      e.last_byte = (p == LastByte);
      expected_bytes.push_back(e);
      hdr_pos = (p == LastByte) ? 5'd0 : p + 5'd1;
      running_crc = c;
   endtask

   always @(posedge clock) begin
      rewritten_byte_type e;
      if (reset) begin
         expected_bytes.delete();
         error_count = 0;
         hdr_pos = '0;
         running_crc = '0;
         flag_on = 1'b0;
         ip_word = '0;
         mask_word = '0;
         gw_word = '0;
         dns_word = '0;
      end else begin
         // the result leaving now is always older than the item entering now
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected item: out_byte %h last_byte %b", rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               e = expected_bytes.pop_front();
               if (rsp_tdata !== e.out_byte) begin
                  $error("out_byte: expected %h, actual %h", e.out_byte, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== e.last_byte) begin
                  $error("last_byte: expected %b, actual %b", e.last_byte, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            rewrite_byte(req_tdata, req_tuser);
         end
         if (csr_we) begin
            case (csr_addr)
               ahrc_pkg::CsrDhcpEnable: flag_on = csr_wdata[0];
               ahrc_pkg::CsrIpAddress:  ip_word = csr_wdata;
               ahrc_pkg::CsrNetMask:    mask_word = csr_wdata;
               ahrc_pkg::CsrGateway:    gw_word = csr_wdata;
               ahrc_pkg::CsrDns:        dns_word = csr_wdata;
               default: ;
            endcase
         end
      end
      pending_count = expected_bytes.size();
   end

endmodule

FILE: sim/auth_header_rewrite_crc16_tb.sv
// Testbench top for the header rewriter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module auth_header_rewrite_crc16_tb;

   localparam int CycleLimit   = 200000;
   localparam int HeaderLen    = 23;
   localparam int SegmentItems = 218;
   localparam int DrainCycles  = 4;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [7:0]                        req_tdata = 8'h00;   // [7:0] in_byte
   logic                              req_tuser = 1'b0;    // [0] first
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [7:0]                        rsp_tdata;           // [7:0] out_byte
   logic                              rsp_tlast;
   logic                              csr_we = 1'b0;
   logic [ahrc_pkg::CsrAddrWidth-1:0] csr_addr = '0;
   logic [ahrc_pkg::CsrDataWidth-1:0] csr_wdata = '0;

   int error_count;
   int pending_count;
   int send_idle = 34;
   int recv_idle = 54;
   int sent_items = 0;
   int cycle_count = 0;

   always #5 clock = ~clock;

   auth_header_rewrite_crc16 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   auth_header_rewrite_crc16_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("auth_header_rewrite_crc16_tb: errors");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // entered and left at a falling edge; valid stays high into the next item
   task automatic send_byte(input logic [7:0] b, input logic first);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= first;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent_items++;
   endtask

   // header bytes from position 0; count below HeaderLen leaves it cut short
   task automatic send_header(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         send_byte(8'($urandom), i == 0);
      end
   endtask

   task automatic send_noise(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         send_byte(8'($urandom), 1'($urandom_range(1)));
      end
   endtask

   task automatic write_regs(input logic [31:0] dhcp, input logic [31:0] ip,
                             input logic [31:0] mask, input logic [31:0] gw,
                             input logic [31:0] dns);
      csr_we <= 1'b1;
      csr_addr <= ahrc_pkg::CsrDhcpEnable;
      csr_wdata <= dhcp;
      @(negedge clock);
      csr_addr <= ahrc_pkg::CsrIpAddress;
      csr_wdata <= ip;
      @(negedge clock);
      csr_addr <= ahrc_pkg::CsrNetMask;
      csr_wdata <= mask;
      @(negedge clock);
      csr_addr <= ahrc_pkg::CsrGateway;
      csr_wdata <= gw;
      @(negedge clock);
      csr_addr <= ahrc_pkg::CsrDns;
      csr_wdata <= dns;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic run_segment(input int items);
      int target;
      int pick;
      target = sent_items + items;
      while (sent_items < target) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            send_header(HeaderLen);
         end else if (pick < 88) begin
            // next header's first flag lands mid-header, any position
            send_header($urandom_range(HeaderLen - 1, 1));
         end else begin
            send_noise($urandom_range(10, 1));
         end
      end
   endtask

   initial begin
      int seg;
      int i;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed header under reset settings, restarted at byte 5
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hFE, 1'b0);
      // bytes 4 to 22: inputs must be ignored
      for (i = 4; i < HeaderLen; i++) begin
         send_byte(i[0] ? 8'hFF : 8'h00, 1'b0);
      end
      drain();

      for (seg = 0; seg < 6; seg++) begin
         case (seg)
            0: write_regs('1, '1, '1, '1, '1);
            // upper bits of the flag register must not matter
            1: write_regs(32'hFFFF_FFFE, '0, '0, '0, '0);
            default: write_regs($urandom, $urandom, $urandom, $urandom, $urandom);
         endcase
         if (seg == 2) begin
            send_idle = 54;
            recv_idle = 34;
         end else if (seg == 4) begin
            send_idle = 0;
            recv_idle = 0;
         end
         run_segment(SegmentItems);
         drain();
      end

      if (error_count == 0 && pending_count == 0) begin
         $display("auth_header_rewrite_crc16_tb: clean");
      end else begin
         $display("auth_header_rewrite_crc16_tb: errors");
      end
      $finish;
   end

endmodule

FILE: auth_header_rewrite_crc16.f
+incdir+sv
sv/ahrc_pkg.sv
sv/ahrc_csr.sv
sv/ahrc_core.sv
sv/auth_header_rewrite_crc16.sv
sim/auth_header_rewrite_crc16_check.sv
sim/auth_header_rewrite_crc16_tb.sv
